// ----- rtl/core/odtl_pkg.sv -----
// Shared types, constants and helpers for the on-demand traffic light sequencer.
package odtl_pkg;

   // Tick counter width and its largest value
   localparam int TICK_BITS = 17;
   localparam int TICK_MAX_W = 33;
   localparam logic [TICK_MAX_W-1:0] TICK_MAX = (TICK_MAX_W'(1) << TICK_BITS) - TICK_MAX_W'(1);

   // Register field widths
   localparam int LONG_W = 17;
   localparam int HALF_W = 16;
   localparam int TOG_W = 4;
   localparam int PHASE_W = 3;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PHASE_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_HALF_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_TOGGLES = 2'd2;

   // Register reset values
   localparam logic [LONG_W-1:0] LONG_PHASE_TICKS_RST = 17'd78125;
   localparam logic [HALF_W-1:0] BLINK_HALF_TICKS_RST = 16'd7812;
   localparam logic [TOG_W-1:0] BLINK_TOGGLES_RST = 4'd10;

   // Light phases
   typedef enum logic [PHASE_W-1:0] {
      PH_GREEN = 3'd0,
      PH_YEL1 = 3'd1,
      PH_RED = 3'd2,
      PH_HOLD = 3'd3,
      PH_YEL2 = 3'd4
   } phase_type;

   // Clip a limit to the counter range; zero acts as one
   function automatic logic [TICK_BITS-1:0] clip_limit(input logic [LONG_W-1:0] v);
      logic [TICK_MAX_W-1:0] wide;
      logic [TICK_MAX_W-1:0] lim;
      begin
         wide = TICK_MAX_W'(v);
         if (wide > TICK_MAX) begin
            lim = TICK_MAX;
         end else if (wide == '0) begin
            lim = TICK_MAX_W'(1);
         end else begin
            lim = wide;
         end
         clip_limit = lim[TICK_BITS-1:0];
      end
   endfunction

endpackage

// ----- rtl/core/on_demand_traffic_light.sv -----
// Top level of the on-demand traffic light sequencer: phase state, tick counters, result word.
// The response word of an accepted request word is in the output register in the cycle after it is accepted.
// Throughput: one word per cycle unless stalled; the output refills in the cycle it is taken.
// The phase update is a single pass over the phase, tick, toggle and yellow registers.
// Reset (synchronous, active high) enters green with counters cleared, yellow level one,
// and loads the timing registers with 78125 and 7812 ticks and 10 toggles.
module on_demand_traffic_light (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_timer_overflow,
   input  logic                                 req_button_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_green_pair,
   output logic                                 rsp_yellow_pair,
   output logic                                 rsp_red_pair,
   output logic [odtl_pkg::PHASE_W-1:0]         rsp_phase_now,
   input  logic                                 csr_write_en,
   input  logic [odtl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [odtl_pkg::LONG_W-1:0]          csr_wdata
);

   // Timing registers
   logic [odtl_pkg::LONG_W-1:0] long_ticks_ff;
   logic [odtl_pkg::HALF_W-1:0] half_ticks_ff;
   logic [odtl_pkg::TOG_W-1:0]  toggles_ff;

   // Sequencer state
   odtl_pkg::phase_type           phase_ff, phase_in;
   logic [odtl_pkg::TICK_BITS-1:0] tick_ff, tick_in;
   logic [odtl_pkg::TOG_W-1:0]     toggle_ff, toggle_in;
   logic                           yellow_ff, yellow_in;

   // Response register
   logic                           rsp_valid_ff;
   logic                           green_ff, green_in;
   logic                           amber_ff, amber_in;
   logic                           red_ff, red_in;
   logic [odtl_pkg::PHASE_W-1:0]   phase_out_ff, phase_out_in;

   // Limits and counter arithmetic
   logic [odtl_pkg::TICK_BITS-1:0] lim_long;
   logic [odtl_pkg::TICK_BITS-1:0] lim_half;
   logic [odtl_pkg::TOG_W-1:0]     lim_tog;
   logic [odtl_pkg::TICK_BITS:0]   tick_sum;
   logic                           long_done;
   logic                           half_done;
   logic [odtl_pkg::TOG_W-1:0]     tog_sum;
   logic                           req_fire;

   // Accept while the output register is empty or being taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire = req_valid & ~req_stall;

   assign lim_long = odtl_pkg::clip_limit(long_ticks_ff);
   assign lim_half = odtl_pkg::clip_limit(odtl_pkg::LONG_W'(half_ticks_ff));
   assign lim_tog = (toggles_ff == '0) ? odtl_pkg::TOG_W'(1) : toggles_ff;

   assign tick_sum = {1'b0, tick_ff} + (odtl_pkg::TICK_BITS+1)'(1);
   assign long_done = tick_sum >= {1'b0, lim_long};
   assign half_done = tick_sum >= {1'b0, lim_half};
   assign tog_sum = toggle_ff + odtl_pkg::TOG_W'(1);

   // Write timing registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff <= odtl_pkg::LONG_PHASE_TICKS_RST;
         half_ticks_ff <= odtl_pkg::BLINK_HALF_TICKS_RST;
         toggles_ff <= odtl_pkg::BLINK_TOGGLES_RST;
      end else if (csr_write_en) begin
         if (csr_index == odtl_pkg::CSR_LONG_PHASE_TICKS) begin
            long_ticks_ff <= csr_wdata;
         end
         if (csr_index == odtl_pkg::CSR_BLINK_HALF_TICKS) begin
            half_ticks_ff <= csr_wdata[odtl_pkg::HALF_W-1:0];
         end
         if (csr_index == odtl_pkg::CSR_BLINK_TOGGLES) begin
            toggles_ff <= csr_wdata[odtl_pkg::TOG_W-1:0];
         end
      end
   end

   // Advance the phase on each accepted tick word
   always_comb begin
      phase_in = phase_ff;
      tick_in = tick_ff;
      toggle_in = toggle_ff;
      yellow_in = yellow_ff;
      if (req_fire && req_timer_overflow) begin
         unique case (phase_ff)
            odtl_pkg::PH_YEL1, odtl_pkg::PH_YEL2: begin
               if (half_done) begin
                  tick_in = '0;
                  yellow_in = ~yellow_ff;
                  toggle_in = tog_sum;
                  // End the blink after the last toggle
                  if (tog_sum == '0 || tog_sum >= lim_tog) begin
                     phase_in = (phase_ff == odtl_pkg::PH_YEL1) ? odtl_pkg::PH_RED
                                                                : odtl_pkg::PH_GREEN;
                  end
               end else begin
                  tick_in = tick_sum[odtl_pkg::TICK_BITS-1:0];
               end
            end
            odtl_pkg::PH_RED: begin
               if (req_button_level) begin
                  phase_in = odtl_pkg::PH_HOLD;
                  tick_in = '0;
               end else if (long_done) begin
                  phase_in = odtl_pkg::PH_YEL2;
                  tick_in = '0;
                  toggle_in = '0;
                  yellow_in = 1'b1;
               end else begin
                  tick_in = tick_sum[odtl_pkg::TICK_BITS-1:0];
               end
            end
            odtl_pkg::PH_HOLD: begin
               if (long_done) begin
                  phase_in = odtl_pkg::PH_YEL2;
                  tick_in = '0;
                  toggle_in = '0;
                  yellow_in = 1'b1;
               end else begin
                  tick_in = tick_sum[odtl_pkg::TICK_BITS-1:0];
               end
            end
            default: begin
               // Green, and any stray code acts as green
               if (req_button_level || long_done) begin
                  phase_in = odtl_pkg::PH_YEL1;
                  tick_in = '0;
                  toggle_in = '0;
                  yellow_in = 1'b1;
               end else begin
                  tick_in = tick_sum[odtl_pkg::TICK_BITS-1:0];
               end
            end
         endcase
      end
   end

   // Decode lamp drives from the new phase
   always_comb begin
      green_in = 1'b0;
      amber_in = 1'b0;
      red_in = 1'b0;
      phase_out_in = phase_in;
      unique case (phase_in)
         odtl_pkg::PH_YEL1, odtl_pkg::PH_YEL2: begin
            amber_in = yellow_in;
         end
         odtl_pkg::PH_RED, odtl_pkg::PH_HOLD: begin
            red_in = 1'b1;
         end
         default: begin
            green_in = 1'b1;
            phase_out_in = odtl_pkg::PH_GREEN;
         end
      endcase
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= odtl_pkg::PH_GREEN;
         tick_ff <= '0;
         toggle_ff <= '0;
         yellow_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         tick_ff <= tick_in;
         toggle_ff <= toggle_in;
         yellow_ff <= yellow_in;
      end
   end

   // Track response word occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load response word on accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         green_ff <= green_in;
         amber_ff <= amber_in;
         red_ff <= red_in;
         phase_out_ff <= phase_out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_green_pair = green_ff;
   assign rsp_yellow_pair = amber_ff;
   assign rsp_red_pair = red_ff;
   assign rsp_phase_now = phase_out_ff;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the on-demand traffic light sequencer.
module testbench;

   localparam logic [odtl_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      logic                         green;
      logic                         yellow;
      logic                         red;
      logic [odtl_pkg::PHASE_W-1:0] phase;
   } lamp_word_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_timer_overflow = 1'b0;
   logic                           req_button_level = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_green_pair;
   logic                           rsp_yellow_pair;
   logic                           rsp_red_pair;
   logic [odtl_pkg::PHASE_W-1:0]   rsp_phase_now;
   logic                           csr_write_en = 1'b0;
   logic [odtl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [odtl_pkg::LONG_W-1:0]    csr_wdata = '0;

   // Light model: timing registers and sequencer state
   logic [odtl_pkg::LONG_W-1:0]    cfg_long = odtl_pkg::LONG_PHASE_TICKS_RST;
   logic [odtl_pkg::HALF_W-1:0]    cfg_half = odtl_pkg::BLINK_HALF_TICKS_RST;
   logic [odtl_pkg::TOG_W-1:0]     cfg_toggles = odtl_pkg::BLINK_TOGGLES_RST;
   odtl_pkg::phase_type            cur_phase = odtl_pkg::PH_GREEN;
   logic [odtl_pkg::TICK_BITS:0]   tick_cnt = '0;
   logic [odtl_pkg::TOG_W-1:0]     toggle_cnt = '0;
   logic                           yellow_lvl = 1'b1;

   lamp_word_type lamp_expect_q[$];
   int            err_count = 0;
   bit            idle_on = 1'b1;

   on_demand_traffic_light uut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // Enter a phase: clear the tick count; for a yellow phase, restart the yellow blink
   function automatic void enter_phase(input odtl_pkg::phase_type p);
      cur_phase = p;
      tick_cnt = '0;
      if (p == odtl_pkg::PH_YEL1 || p == odtl_pkg::PH_YEL2) begin
         toggle_cnt = '0;
         yellow_lvl = 1'b1;
      end
   endfunction

   // Count one tick; report whether the limit is reached
   function automatic logic limit_reached(input logic [odtl_pkg::TICK_BITS:0] limit);
      if (tick_cnt + 1'b1 >= limit) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 1'b1;
      return 1'b0;
   endfunction

   // Advance the light model by one word and queue the lamp word it shows
   task automatic advance_lights(input logic tick, input logic press);
      logic [odtl_pkg::TICK_BITS:0] lim_long;
      logic [odtl_pkg::TICK_BITS:0] lim_half;
      logic [odtl_pkg::TOG_W-1:0]   lim_tog;
      lamp_word_type                w;
      lim_long = (cfg_long == '0) ? (odtl_pkg::TICK_BITS + 1)'(1)
                                  : (odtl_pkg::TICK_BITS + 1)'(cfg_long);
      lim_half = (cfg_half == '0) ? (odtl_pkg::TICK_BITS + 1)'(1)
                                  : (odtl_pkg::TICK_BITS + 1)'(cfg_half);
      lim_tog = (cfg_toggles == '0) ? odtl_pkg::TOG_W'(1) : cfg_toggles;
      if (tick) begin
         case (cur_phase)
            odtl_pkg::PH_YEL1, odtl_pkg::PH_YEL2: begin
               if (limit_reached(lim_half)) begin
                  yellow_lvl = ~yellow_lvl;
                  toggle_cnt = toggle_cnt + 1'b1;
                  if (toggle_cnt == '0 || toggle_cnt >= lim_tog) begin
                     enter_phase(cur_phase == odtl_pkg::PH_YEL1 ? odtl_pkg::PH_RED
                                                                : odtl_pkg::PH_GREEN);
                  end
               end
            end
            odtl_pkg::PH_RED: begin
               if (press) begin
                  enter_phase(odtl_pkg::PH_HOLD);
               end else if (limit_reached(lim_long)) begin
                  enter_phase(odtl_pkg::PH_YEL2);
               end
            end
            odtl_pkg::PH_HOLD: begin
               if (limit_reached(lim_long)) begin
                  enter_phase(odtl_pkg::PH_YEL2);
               end
            end
            default: begin
               if (press) begin
                  enter_phase(odtl_pkg::PH_YEL1);
               end else if (limit_reached(lim_long)) begin
                  enter_phase(odtl_pkg::PH_YEL1);
               end
            end
         endcase
      end
      w = '0;
      w.phase = cur_phase;
      if (cur_phase == odtl_pkg::PH_YEL1 || cur_phase == odtl_pkg::PH_YEL2) begin
         w.yellow = yellow_lvl;
      end else if (cur_phase == odtl_pkg::PH_RED || cur_phase == odtl_pkg::PH_HOLD) begin
         w.red = 1'b1;
      end else begin
         w.green = 1'b1;
         w.phase = odtl_pkg::PH_GREEN;
      end
      lamp_expect_q.push_back(w);
   endtask

   // Send one request word after a random gap when gaps are on; predict it once it is taken
   task automatic send_word(input logic tick, input logic press);
      int gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_timer_overflow <= tick;
      req_button_level <= press;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      advance_lights(tick, press);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic settle_lights();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (lamp_expect_q.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (lamp_expect_q.size() != 0) begin
         report_mismatch("words never returned", 0, lamp_expect_q.size());
         lamp_expect_q.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   // Write one timing register while the block is idle
   task automatic write_reg(input logic [odtl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [odtl_pkg::LONG_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         odtl_pkg::CSR_LONG_PHASE_TICKS: cfg_long = value;
         odtl_pkg::CSR_BLINK_HALF_TICKS: cfg_half = value[odtl_pkg::HALF_W-1:0];
         odtl_pkg::CSR_BLINK_TOGGLES:    cfg_toggles = value[odtl_pkg::TOG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [odtl_pkg::LONG_W-1:0] long_ticks,
                             input logic [odtl_pkg::LONG_W-1:0] half_ticks,
                             input logic [odtl_pkg::LONG_W-1:0] toggles);
      write_reg(odtl_pkg::CSR_LONG_PHASE_TICKS, long_ticks);
      write_reg(odtl_pkg::CSR_BLINK_HALF_TICKS, half_ticks);
      write_reg(odtl_pkg::CSR_BLINK_TOGGLES, toggles);
   endtask

   // Check each lamp word against the oldest prediction; stall at random
   always @(posedge clock) begin
      static int hold_left = 0;
      lamp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (lamp_expect_q.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = lamp_expect_q.pop_front();
               if (rsp_green_pair !== want.green)
                  report_mismatch("green_pair", rsp_green_pair, want.green);
               if (rsp_yellow_pair !== want.yellow)
                  report_mismatch("yellow_pair", rsp_yellow_pair, want.yellow);
               if (rsp_red_pair !== want.red)
                  report_mismatch("red_pair", rsp_red_pair, want.red);
               if (rsp_phase_now !== want.phase)
                  report_mismatch("phase_now", rsp_phase_now, want.phase);
            end
            hold_left = idle_on ? $urandom_range(0, 10) : 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Reset timing: ignored button without tick, a counted tick, a press ending green
   task automatic test_power_on();
      send_word(1'b0, 1'b1);
      send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b1);
      send_word(1'b0, 1'b1);
      send_word(1'b1, 1'b1);
      settle_lights();
   endtask

   // Walk the green, yellow and red phases with zero blink limits acting as one, then a full blink count
   task automatic test_phase_walk();
      set_timing(17'd2, 17'd0, 17'd0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b1);
      send_word(1'b1, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b0);
      send_word(1'b1, 1'b1);
      settle_lights();
      set_timing(17'd0, 17'd1, 17'd15);
      repeat (40) send_word(1'b1, 1'b0);
      settle_lights();
   endtask

   // Lower the limits while a phase is part way through its count
   task automatic test_limit_lowered();
      repeat (3) begin
         set_timing(17'd40, 17'd30, 17'd15);
         repeat ($urandom_range(10, 60)) send_word(1'b1, 1'b0);
         settle_lights();
         set_timing(17'd3, 17'd2, 17'd2);
         repeat (12) send_word(1'b1, $urandom_range(0, 5) == 0);
         settle_lights();
      end
   endtask

   // Write past the register list; timing must not change
   task automatic test_unused_index();
      set_timing(17'd5, 17'd2, 17'd3);
      write_reg(CSR_UNUSED_IDX, 17'h1FFFF);
      write_reg(CSR_UNUSED_IDX, odtl_pkg::LONG_W'($urandom));
      repeat (40) send_word($urandom_range(0, 7) != 0, $urandom_range(0, 5) == 0);
      settle_lights();
   endtask

   // Largest register values: only presses end green and red
   task automatic test_extremes();
      set_timing(17'h1FFFF, 17'hFFFF, 17'hF);
      repeat (30) send_word($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
      settle_lights();
   endtask

   // Random timing in most rounds (fixed in round 0, partly in round 5); mostly ticks, some presses and idle words
   task automatic test_random_traffic();
      int ticks;
      int press_odds;
      logic tick;
      for (int round = 0; round < 10; round++) begin
         if (round == 0) begin
            set_timing(17'd1, 17'd1, 17'd1);
         end else if (round == 5) begin
            set_timing(odtl_pkg::LONG_W'($urandom_range(100, 400)), 17'd3, 17'd2);
         end else begin
            set_timing(odtl_pkg::LONG_W'($urandom_range(0, 12)),
                       odtl_pkg::LONG_W'($urandom_range(0, 6)),
                       odtl_pkg::LONG_W'($urandom_range(0, 15)));
         end
         idle_on = (round % 4) != 2;
         press_odds = $urandom_range(3, 40);
         ticks = 0;
         while (ticks < 120) begin
            tick = $urandom_range(0, 9) != 0;
            send_word(tick, $urandom_range(0, press_odds) == 0);
            if (tick) ticks++;
         end
         settle_lights();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_power_on();
      test_phase_walk();
      test_limit_lowered();
      test_unused_index();
      test_extremes();
      test_random_traffic();
      settle_lights();
      repeat (5) @(posedge clock);
      if (err_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Hard stop for a hung handshake
   initial begin
      #5000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
